FILE: hdl/pqf_pkg.sv
// Package of shared constants for the prefetch queue filter.
`default_nettype none
package pqf_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_ISSUE   = 4;
  localparam int POP_W       = $clog2(MAX_ISSUE + 1);
  localparam int ADDR_W      = 32;
  localparam int CTR_W       = 32;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 136;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_PER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 2'd2;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [1:0] KIND_ENQ     = 2'd0;
  localparam logic [1:0] KIND_ISSUED  = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;

  localparam logic [1:0] OC_QUEUED   = 2'd0;
  localparam logic [1:0] OC_FILTERED = 2'd1;
  localparam logic [1:0] OC_DUP      = 2'd2;
  localparam logic [1:0] OC_DROPPED  = 2'd3;
endpackage
`default_nettype wire

FILE: hdl/prefetch_queue_filter_core.sv
// Prefetch request queue with a serial block-address duplicate filter.
//
// Input words arrive on in_t*: in_tuser is the action (0 enqueue, 1 tick),
// in_tdata carries pf_addr and the in_l1 flag. An enqueue gives one result
// word; a tick pops up to issue_per_tick addresses from the queue head and
// gives one word per address, the final one marked by out_tlast, or a single
// nothing-issued word when nothing can be popped. Configuration words on
// cfg_* are always accepted and should be written while the block is idle.
// The block works on one input word at a time and is not ready meanwhile.
// One shared comparator walks the queued entries one memory read per cycle,
// so an enqueue result waits until the scan meets a duplicate or has read
// every entry, and the block is ready for the next word as the result
// appears; a filtered word skips the scan. A tick does, for each popped
// address, a memory read followed by the output load.
// Results sit in an output register; a stalled receiver holds the block in
// the state that waits to load the next word, and the next input word is
// still taken while the last result of the previous one waits.
// Reset clears the queue, the three counters and the output, and restores
// the register defaults: limit 16, one issue per tick, 64-byte lines.
`default_nettype none
module prefetch_queue_filter_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // Bits from the lowest: pf_addr[31:0], in_l1[32], zero fill.
  input  wire logic [pqf_pkg::IN_DATA_W-1:0]      in_tdata,
  // Bit 0: action.
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // Bits from the lowest: outcome[1:0], issued_addr[33:2], occupancy[38:34],
  // filtered_count[70:39], duplicate_count[102:71], drop_count[134:103], zero.
  output logic [pqf_pkg::OUT_DATA_W-1:0]          out_tdata,
  // Bits from the lowest: kind[1:0].
  output logic [1:0]                              out_tuser,
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pqf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pqf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_EMIT   = 5'b00100,
    S_POP_RD = 5'b01000,
    S_POP_WR = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [pqf_pkg::ADDR_W-1:0] mem_r [pqf_pkg::QUEUE_DEPTH];
  logic [pqf_pkg::ADDR_W-1:0] rdata_r;
  logic                        rd_en;
  logic [pqf_pkg::SLOT_W-1:0] rd_slot;
  logic                        wr_en;
  logic [pqf_pkg::SLOT_W-1:0] wr_slot;

  logic [4:0] limit_r;
  logic [2:0] issue_r;
  logic [3:0] offs_r;

  logic [pqf_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic [pqf_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [pqf_pkg::CTR_W-1:0]  filt_r, filt_nxt, dup_r, dup_nxt, drop_r, drop_nxt;

  logic [pqf_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [pqf_pkg::ADDR_W-1:0] blk_r, blk_nxt;
  logic [pqf_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic [1:0]                  oc_r, oc_nxt;
  logic [pqf_pkg::POP_W-1:0]  pops_r, pops_nxt;
  logic [pqf_pkg::POP_W-1:0]  popped_r, popped_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_kind_r, out_kind_nxt;
  logic [1:0]                  out_oc_r, out_oc_nxt;
  logic [pqf_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [pqf_pkg::ADDR_W-1:0] mask;
  logic [pqf_pkg::CNT_W-1:0]  limit_eff;
  logic [pqf_pkg::POP_W-1:0]  issue_eff;
  logic [pqf_pkg::POP_W-1:0]  pops_calc;
  logic                        out_free;
  logic                        in_fire;

  assign mask      = {pqf_pkg::ADDR_W{1'b1}} << offs_r;
  assign limit_eff = (limit_r > 5'(pqf_pkg::QUEUE_DEPTH)) ?
                     pqf_pkg::CNT_W'(pqf_pkg::QUEUE_DEPTH) : pqf_pkg::CNT_W'(limit_r);
  assign issue_eff = (issue_r > 3'(pqf_pkg::MAX_ISSUE)) ?
                     pqf_pkg::POP_W'(pqf_pkg::MAX_ISSUE) : pqf_pkg::POP_W'(issue_r);
  assign pops_calc = (pqf_pkg::CNT_W'(issue_eff) < count_r) ?
                     issue_eff : pqf_pkg::POP_W'(count_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    filt_nxt      = filt_r;
    dup_nxt       = dup_r;
    drop_nxt      = drop_r;
    addr_nxt      = addr_r;
    blk_nxt       = blk_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = 1'b0;
    kind_nxt      = kind_r;
    oc_nxt        = oc_r;
    pops_nxt      = pops_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_oc_nxt    = out_oc_r;
    out_addr_nxt  = out_addr_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_slot       = head_r;
    wr_en         = 1'b0;
    wr_slot       = head_r + count_r[pqf_pkg::SLOT_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          addr_nxt = in_tdata[pqf_pkg::ADDR_W-1:0];
          blk_nxt  = in_tdata[pqf_pkg::ADDR_W-1:0] & mask;
          idx_nxt  = '0;
          oc_nxt   = pqf_pkg::OC_QUEUED;
          popped_nxt = '0;
          pops_nxt = pops_calc;
          if (in_tuser == pqf_pkg::ACT_TICK) begin
            if (pops_calc == '0) begin
              kind_nxt  = pqf_pkg::KIND_NOTHING;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_POP_RD;
            end
          end else begin
            kind_nxt = pqf_pkg::KIND_ENQ;
            if (in_tdata[pqf_pkg::ADDR_W]) begin
              oc_nxt    = pqf_pkg::OC_FILTERED;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_pend_r && ((rdata_r & mask) == blk_r)) begin
          oc_nxt    = pqf_pkg::OC_DUP;
          state_nxt = S_EMIT;
        end else if (idx_r < count_r) begin
          rd_en       = 1'b1;
          rd_slot     = head_r + idx_r[pqf_pkg::SLOT_W-1:0];
          rd_pend_nxt = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          oc_nxt    = (count_r >= limit_eff) ? pqf_pkg::OC_DROPPED : pqf_pkg::OC_QUEUED;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_oc_nxt    = (kind_r == pqf_pkg::KIND_ENQ) ? oc_r : pqf_pkg::OC_QUEUED;
          out_addr_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          if (kind_r == pqf_pkg::KIND_ENQ) begin
            case (oc_r)
              pqf_pkg::OC_QUEUED: begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
              pqf_pkg::OC_FILTERED: filt_nxt = filt_r + 1'b1;
              pqf_pkg::OC_DUP:      dup_nxt  = dup_r + 1'b1;
              default:              drop_nxt = drop_r + 1'b1;
            endcase
          end
        end
      end
      S_POP_RD: begin
        rd_en     = 1'b1;
        rd_slot   = head_r;
        state_nxt = S_POP_WR;
      end
      S_POP_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pqf_pkg::KIND_ISSUED;
          out_oc_nxt    = pqf_pkg::OC_QUEUED;
          out_addr_nxt  = rdata_r;
          out_last_nxt  = (popped_r + 1'b1) == pops_r;
          head_nxt      = head_r + 1'b1;
          count_nxt     = count_r - 1'b1;
          popped_nxt    = popped_r + 1'b1;
          state_nxt     = ((popped_r + 1'b1) == pops_r) ? S_IDLE : S_POP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[rd_slot];
    end
    if (wr_en) begin
      mem_r[wr_slot] <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      filt_r      <= '0;
      dup_r       <= '0;
      drop_r      <= '0;
      rd_pend_r   <= 1'b0;
      idx_r       <= '0;
      popped_r    <= '0;
      pops_r      <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= 5'd16;
      issue_r     <= 3'd1;
      offs_r      <= 4'd6;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      filt_r      <= filt_nxt;
      dup_r       <= dup_nxt;
      drop_r      <= drop_nxt;
      rd_pend_r   <= rd_pend_nxt;
      idx_r       <= idx_nxt;
      popped_r    <= popped_nxt;
      pops_r      <= pops_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pqf_pkg::CFG_QUEUE_LIMIT: limit_r <= cfg_data;
          pqf_pkg::CFG_ISSUE_PER:   issue_r <= cfg_data[2:0];
          pqf_pkg::CFG_LINE_OFFSET: offs_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    blk_r      <= blk_nxt;
    kind_r     <= kind_nxt;
    oc_r       <= oc_nxt;
    out_kind_r <= out_kind_nxt;
    out_oc_r   <= out_oc_nxt;
    out_addr_r <= out_addr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, drop_r, dup_r, filt_r, count_r, out_addr_r, out_oc_r};

endmodule
`default_nettype wire
